### src/sdfc_pkg.sv
`default_nettype none
package sdfc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int PLANE_AW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // request codes on req_type
   localparam logic [1:0] REQ_FRAME = 2'd0;
   localparam logic [1:0] REQ_PLANE = 2'd1;
   localparam logic [1:0] REQ_MESH  = 2'd2;

   // cull reasons
   localparam logic [1:0] REASON_NONE    = 2'd0;
   localparam logic [1:0] REASON_RANGE   = 2'd1;
   localparam logic [1:0] REASON_FRUSTUM = 2'd2;

   localparam logic [63:0] VDSQ_RESET  = 64'hFFFF_FE00_0001_0000;
   localparam logic [33:0] NORMAL_CAP  = 34'd131071;
   localparam logic [33:0] OFF_POS_CAP = 34'h0_7FFF_FFFF;
   localparam logic [33:0] OFF_NEG_CAP = 34'h0_8000_0000;

   typedef enum logic [1:0] {
      KIND_FRAME,
      KIND_PLANE,
      KIND_MESH
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [PLANE_AW-1:0]   plane;
      logic signed [31:0]    x;
      logic signed [31:0]    y;
      logic signed [31:0]    z;
      logic signed [31:0]    w;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Z,
      ST_DIST,
      ST_PLANE,
      ST_REPORT,
      ST_SCALE,
      ST_SUMSQ,
      ST_ROOT,
      ST_DIV,
      ST_STORE
   } back_state_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? 32'(-v) : v;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

endpackage
`default_nettype wire

### src/sdfc_front.sv
`default_nettype none
module sdfc_front
   import sdfc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         req_type,
   input  wire logic [2:0]         req_plane_index,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic signed [31:0] req_coord_w,
   input  wire queue_status_type   qstat,
   output logic                    busy,
   output logic                    push,
   output item_type                item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept, keep;
   kind_type kind;

   // drop unused request codes and plane writes beyond the last plane
   always_comb begin
      kind = KIND_MESH;
      keep = 1'b0;
      unique case (req_type)
         REQ_FRAME: begin
            kind = KIND_FRAME;
            keep = 1'b1;
         end
         REQ_PLANE: begin
            kind = KIND_PLANE;
            keep = (4'(req_plane_index) < 4'(PLANE_COUNT));
         end
         REQ_MESH: begin
            kind = KIND_MESH;
            keep = 1'b1;
         end
         default: begin
            kind = KIND_MESH;
            keep = 1'b0;
         end
      endcase
   end

   assign busy     = valid_ff & qstat.full;
   assign push     = valid_ff & ~qstat.full;
   assign accept   = start & ~busy;
   assign valid_in = (accept & keep) | (valid_ff & ~push);
   assign item     = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept & keep) begin
         item_ff.kind  <= kind;
         item_ff.plane <= PLANE_AW'(req_plane_index);
         item_ff.x     <= req_coord_x;
         item_ff.y     <= req_coord_y;
         item_ff.z     <= req_coord_z;
         item_ff.w     <= req_coord_w;
      end
   end

endmodule
`default_nettype wire

### src/sdfc_queue.sv
`default_nettype none
module sdfc_queue
   import sdfc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr,
   input  wire item_type         wr_item,
   input  wire logic             rd,
   output item_type              head,
   output queue_status_type      qstat
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, rptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
      bump = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
   endfunction

   assign head        = mem_ff[rptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (wr) begin
            wptr_ff <= bump(wptr_ff);
         end
         if (rd) begin
            rptr_ff <= bump(rptr_ff);
         end
         if (wr & ~rd) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (rd & ~wr) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wptr_ff] <= wr_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr |-> (!qstat.full || rd))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd |-> !qstat.empty)
      else $error("queue read while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (wr && !rd) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count did not advance on write");
`endif

endmodule
`default_nettype wire

### src/sdfc_back.sv
`default_nettype none
module sdfc_back
   import sdfc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [23:0]      csr_wdata,
   input  wire item_type         head,
   input  wire queue_status_type qstat,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic                  rsp_visible,
   output logic [1:0]            rsp_cull_reason,
   output logic [63:0]           rsp_distance_sq,
   output logic [31:0]           rsp_total_count,
   output logic [31:0]           rsp_visible_count,
   output logic [31:0]           rsp_culled_count,
   output logic [63:0]           rsp_nearest_sq,
   output logic [63:0]           rsp_farthest_sq
);

   back_state_type state_ff, state_in;
   item_type       item_ff;

   logic [63:0] vdsq_ff;
   logic [47:0] vd_prod;

   // camera, statistics, frustum
   logic signed [31:0] camx_ff, camz_ff;
   logic [31:0] tot_ff, vis_ff, cul_ff;
   logic [63:0] near_ff, far_ff;
   logic        fv_ff;
   logic signed [17:0] nrm_ff [PLANE_COUNT][3];
   logic signed [31:0] off_ff [PLANE_COUNT];

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;

   // mesh test
   logic signed [32:0] dx, dz;
   logic [32:0] magx, magz;
   logic        ovx_ff, ovz_ff;
   logic [63:0] sqx_ff, sqz, dsq, dsq_ff;
   logic [64:0] dsum;
   logic [1:0]  reason_ff;
   logic [PLANE_AW-1:0] plane_ff;
   logic [2:0]  phase_ff;
   logic signed [17:0] nsel;
   logic signed [31:0] csel;
   logic signed [49:0] pterm_ff;
   logic signed [63:0] acc_ff, lim, off_ext;
   logic        outside, last_plane;

   // plane normalization
   logic [31:0] m0_ff, m1_ff, m2_ff, orv, msel;
   logic        scaled;
   logic [4:0]  s_ff;
   logic        zero_ff;
   logic [63:0] sum_ff, rx_ff, res_ff, bit_ff, root_t;
   logic [1:0]  comp_ff;
   logic [6:0]  i_ff, diff;
   logic [5:0]  e, e_next;
   logic [31:0] dmag;
   logic [33:0] cap, rem_ff, q_ff, rem2, rem_n, q2, q_n, rq, res_q;
   logic [32:0] len;
   logic        sat_ff, sat_n, bitin, rge;
   logic [16:0] qn_ff [3];
   logic [31:0] qo_ff;
   logic [17:0] nv [3];

   logic [31:0] tot_n, vis_n, cul_n;
   logic [63:0] near_n, far_n;
   logic        visible;

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               unique case (head.kind)
                  KIND_PLANE: state_in = ST_SCALE;
                  KIND_MESH:  state_in = ST_MUL_X;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL_X: state_in = ST_MUL_Z;
         ST_MUL_Z: state_in = ST_DIST;
         ST_DIST: begin
            if (dsq > vdsq_ff || !fv_ff) begin
               state_in = ST_REPORT;
            end else begin
               state_in = ST_PLANE;
            end
         end
         ST_PLANE: begin
            if (phase_ff == 3'd4 && (outside || last_plane)) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: state_in = ST_IDLE;
         ST_SCALE: begin
            if (orv == '0) begin
               state_in = ST_STORE;
            end else if (scaled) begin
               state_in = ST_SUMSQ;
            end
         end
         ST_SUMSQ: begin
            if (phase_ff == 3'd3) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (bit_ff == 64'd1) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (i_ff == '0 && comp_ff == 2'd3) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs of the sequencer
   always_comb begin
      pop   = 1'b0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_IDLE: pop = ~qstat.empty;
         ST_MUL_X: begin
            mul_a = magx[31:0];
            mul_b = magx[31:0];
         end
         ST_MUL_Z: begin
            mul_a = magz[31:0];
            mul_b = magz[31:0];
         end
         ST_SUMSQ: begin
            mul_a = msel;
            mul_b = msel;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // ---------------- datapath
   assign vd_prod = 48'(csr_wdata) * 48'(csr_wdata);

   assign dx   = {item_ff.x[31], item_ff.x} - {camx_ff[31], camx_ff};
   assign dz   = {item_ff.z[31], item_ff.z} - {camz_ff[31], camz_ff};
   assign magx = dx[32] ? 33'(-dx) : 33'(dx);
   assign magz = dz[32] ? 33'(-dz) : 33'(dz);
   assign sqz  = ovz_ff ? '1 : prod_ff;
   assign dsum = {1'b0, sqx_ff} + {1'b0, sqz};
   assign dsq  = dsum[64] ? '1 : dsum[63:0];

   always_comb begin
      unique case (phase_ff)
         3'd0: begin
            nsel = nrm_ff[plane_ff][0];
            csel = item_ff.x;
         end
         3'd1: begin
            nsel = nrm_ff[plane_ff][1];
            csel = item_ff.y;
         end
         default: begin
            nsel = nrm_ff[plane_ff][2];
            csel = item_ff.z;
         end
      endcase
   end

   assign off_ext    = {{16{off_ff[plane_ff][31]}}, off_ff[plane_ff], 16'h0};
   assign lim        = -{{16{item_ff.w[31]}}, item_ff.w, 16'h0};
   assign outside    = (acc_ff < lim);
   assign last_plane = (32'(plane_ff) == PLANE_COUNT - 1);

   // stop shifting once the largest magnitude is above 2^30
   assign orv    = m0_ff | m1_ff | m2_ff;
   assign scaled = (m0_ff > 32'h4000_0000) | (m1_ff > 32'h4000_0000) |
                   (m2_ff > 32'h4000_0000);
   always_comb begin
      unique case (phase_ff)
         3'd0:    msel = m0_ff;
         3'd1:    msel = m1_ff;
         default: msel = m2_ff;
      endcase
   end

   assign root_t = res_ff + bit_ff;

   // one quotient bit per cycle
   assign len    = res_ff[32:0];
   assign e      = (comp_ff == 2'd3) ? 6'd8 + 6'(s_ff) : 6'd16 + 6'(s_ff);
   assign e_next = (comp_ff == 2'd2) ? 6'd8 + 6'(s_ff) : 6'd16 + 6'(s_ff);
   always_comb begin
      unique case (comp_ff)
         2'd0:    dmag = mag32(item_ff.x);
         2'd1:    dmag = mag32(item_ff.y);
         2'd2:    dmag = mag32(item_ff.z);
         default: dmag = mag32(item_ff.w);
      endcase
   end
   assign cap   = (comp_ff != 2'd3) ? NORMAL_CAP :
                  (item_ff.w[31] ? OFF_NEG_CAP : OFF_POS_CAP);
   assign diff  = i_ff - 7'(e);
   assign bitin = (i_ff >= 7'(e)) && (diff < 7'd32) ? dmag[diff[4:0]] : 1'b0;
   assign rem2  = {rem_ff[32:0], bitin};
   assign rge   = (rem2 >= {1'b0, len});
   assign rem_n = rge ? rem2 - {1'b0, len} : rem2;
   assign q2    = {q_ff[32:0], rge};
   assign sat_n = sat_ff | (q2 > cap);
   assign q_n   = sat_n ? cap : q2;
   assign rq    = (!sat_n && {rem_n, 1'b0} >= {2'b0, len}) ? q_n + 34'd1 : q_n;
   assign res_q = (rq > cap) ? cap : rq;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nv[k] = {1'b0, qn_ff[k]};
      end
   end

   // statistics update on report
   assign visible = (reason_ff == REASON_NONE);
   assign tot_n   = sat_inc(tot_ff);
   assign vis_n   = visible ? sat_inc(vis_ff) : vis_ff;
   assign cul_n   = visible ? cul_ff : sat_inc(cul_ff);
   assign near_n  = (visible && dsq_ff < near_ff) ? dsq_ff : near_ff;
   assign far_n   = (visible && dsq_ff > far_ff) ? dsq_ff : far_ff;

   // ---------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vdsq_ff   <= VDSQ_RESET;
         camx_ff   <= '0;
         camz_ff   <= '0;
         tot_ff    <= '0;
         vis_ff    <= '0;
         cul_ff    <= '0;
         near_ff   <= VDSQ_RESET;
         far_ff    <= '0;
         fv_ff     <= 1'b0;
         rsp_valid <= 1'b0;
         phase_ff  <= '0;
         for (int p = 0; p < PLANE_COUNT; p++) begin
            nrm_ff[p][0] <= '0;
            nrm_ff[p][1] <= '0;
            nrm_ff[p][2] <= '0;
            off_ff[p]    <= '0;
         end
      end else begin
         state_ff  <= state_in;
         rsp_valid <= (state_ff == ST_REPORT);
         if (csr_we) begin
            vdsq_ff <= {vd_prod, 16'h0};
         end
         // restart the phase count on every state change
         if (state_in != state_ff) begin
            phase_ff <= '0;
         end else if (state_ff == ST_PLANE && phase_ff == 3'd4) begin
            phase_ff <= '0;
         end else begin
            phase_ff <= phase_ff + 3'd1;
         end
         if (pop && head.kind == KIND_FRAME) begin
            camx_ff <= head.x;
            camz_ff <= head.z;
            tot_ff  <= '0;
            vis_ff  <= '0;
            cul_ff  <= '0;
            near_ff <= vdsq_ff;
            far_ff  <= '0;
         end
         if (state_ff == ST_REPORT) begin
            tot_ff  <= tot_n;
            vis_ff  <= vis_n;
            cul_ff  <= cul_n;
            near_ff <= near_n;
            far_ff  <= far_n;
         end
         if (state_ff == ST_STORE) begin
            if (zero_ff) begin
               nrm_ff[item_ff.plane][0] <= '0;
               nrm_ff[item_ff.plane][1] <= '0;
               nrm_ff[item_ff.plane][2] <= '0;
               off_ff[item_ff.plane]    <= item_ff.w;
            end else begin
               nrm_ff[item_ff.plane][0] <= item_ff.x[31] ? -nv[0] : nv[0];
               nrm_ff[item_ff.plane][1] <= item_ff.y[31] ? -nv[1] : nv[1];
               nrm_ff[item_ff.plane][2] <= item_ff.z[31] ? -nv[2] : nv[2];
               off_ff[item_ff.plane]    <= item_ff.w[31] ? 32'(-qo_ff) : qo_ff;
            end
            if (32'(item_ff.plane) == PLANE_COUNT - 1) begin
               fv_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------- payload registers
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (pop) begin
         item_ff <= head;
         m0_ff   <= mag32(head.x);
         m1_ff   <= mag32(head.y);
         m2_ff   <= mag32(head.z);
         s_ff    <= '0;
         zero_ff <= 1'b0;
      end
      unique case (state_ff)
         ST_MUL_X: ovx_ff <= magx[32];
         ST_MUL_Z: begin
            sqx_ff <= ovx_ff ? '1 : prod_ff;
            ovz_ff <= magz[32];
         end
         ST_DIST: begin
            dsq_ff   <= dsq;
            plane_ff <= '0;
            reason_ff <= (dsq > vdsq_ff) ? REASON_RANGE : REASON_NONE;
         end
         ST_PLANE: begin
            if (phase_ff <= 3'd2) begin
               pterm_ff <= nsel * csel;
            end
            if (phase_ff == 3'd0) begin
               acc_ff <= off_ext;
            end else if (phase_ff <= 3'd3) begin
               acc_ff <= acc_ff + {{14{pterm_ff[49]}}, pterm_ff};
            end else begin
               if (outside) begin
                  reason_ff <= REASON_FRUSTUM;
               end else if (!last_plane) begin
                  plane_ff <= plane_ff + PLANE_AW'(1);
               end
            end
         end
         ST_SCALE: begin
            if (orv == '0) begin
               zero_ff <= 1'b1;
            end else if (!scaled) begin
               m0_ff <= {m0_ff[30:0], 1'b0};
               m1_ff <= {m1_ff[30:0], 1'b0};
               m2_ff <= {m2_ff[30:0], 1'b0};
               s_ff  <= s_ff + 5'd1;
            end
         end
         ST_SUMSQ: begin
            if (phase_ff == 3'd1) begin
               sum_ff <= prod_ff;
            end else if (phase_ff == 3'd2) begin
               sum_ff <= sum_ff + prod_ff;
            end else if (phase_ff == 3'd3) begin
               rx_ff  <= sum_ff + prod_ff;
               res_ff <= '0;
               bit_ff <= 64'd1 << 62;
            end
         end
         ST_ROOT: begin
            if (rx_ff >= root_t) begin
               rx_ff  <= rx_ff - root_t;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            comp_ff <= '0;
            i_ff    <= 7'd16 + 7'(s_ff) + 7'd32;
            rem_ff  <= '0;
            q_ff    <= '0;
            sat_ff  <= 1'b0;
         end
         ST_DIV: begin
            if (i_ff == '0) begin
               if (comp_ff == 2'd3) begin
                  qo_ff <= 32'(res_q);
               end else begin
                  qn_ff[comp_ff] <= 17'(res_q);
               end
               comp_ff <= comp_ff + 2'd1;
               i_ff    <= 7'(e_next) + 7'd32;
               rem_ff  <= '0;
               q_ff    <= '0;
               sat_ff  <= 1'b0;
            end else begin
               i_ff   <= i_ff - 7'd1;
               rem_ff <= rem_n;
               q_ff   <= q_n;
               sat_ff <= sat_n;
            end
         end
         ST_REPORT: begin
            rsp_visible       <= visible;
            rsp_cull_reason   <= reason_ff;
            rsp_distance_sq   <= dsq_ff;
            rsp_total_count   <= tot_n;
            rsp_visible_count <= vis_n;
            rsp_culled_count  <= cul_n;
            rsp_nearest_sq    <= near_n;
            rsp_farthest_sq   <= far_n;
         end
         default: begin
            sat_ff <= sat_ff;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_strobe_from_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_REPORT))
      else $error("result strobe without a report cycle");
   a_frustum_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(fv_ff))
      else $error("frustum valid dropped");
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (res_ff[32:30] != 3'b000))
      else $error("normal length below scaled range");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE && !qstat.empty))
      else $error("queue popped while busy");
`endif

endmodule
`default_nettype wire

### src/sphere_distance_frustum_cull.sv
`default_nettype none
// Bounding-sphere culler against a horizontal view distance and six planes.
// Requests enter on start/req_* and are taken at a clock edge with start
// high and busy low; busy rises only while the front register and the
// two-entry request queue are both full. A frame start latches the camera
// x/z and clears the statistics; a plane write normalizes and stores one
// plane (writing the last plane arms the frustum test); a mesh test yields
// one result. Results appear on rsp_* for exactly one cycle with rsp_valid
// high; the receiver cannot stall, so nothing downstream holds the block.
// A mesh test runs the range test and, when the frustum is armed and the
// range test passes, a plane-term multiply-accumulate for each plane in
// turn until one plane culls or the last plane is tested. A plane write
// occupies the back end for a one-bit-per-cycle scaling shift (up to 31
// shifts), a 32-step square root and four bit-serial divisions; a zero
// normal skips the square root and the divisions. A frame start is
// handled while the back end is idle. The view distance register is
// written through csr_we/csr_wdata; the user must write it only while
// idle, which the block itself does not enforce. Reset clears the planes,
// the statistics and the queue, and sets the view distance to its maximum.
module sphere_distance_frustum_cull
   import sdfc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic [2:0]         req_plane_index,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic signed [31:0] req_coord_w,
   input  wire logic               csr_we,
   input  wire logic [23:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic                    rsp_visible,
   output logic [1:0]              rsp_cull_reason,
   output logic [63:0]             rsp_distance_sq,
   output logic [31:0]             rsp_total_count,
   output logic [31:0]             rsp_visible_count,
   output logic [31:0]             rsp_culled_count,
   output logic [63:0]             rsp_nearest_sq,
   output logic [63:0]             rsp_farthest_sq
);

   // front to queue
   logic             push;
   item_type         front_item;
   // queue to back
   item_type         head;
   queue_status_type qstat;
   logic             pop;

   // classify and hold one request
   sdfc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_type        (req_type),
      .req_plane_index (req_plane_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_coord_w     (req_coord_w),
      .qstat           (qstat),
      .busy            (busy),
      .push            (push),
      .item            (front_item)
   );

   // decouple acceptance from execution
   sdfc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (push),
      .wr_item (front_item),
      .rd      (pop),
      .head    (head),
      .qstat   (qstat)
   );

   // execute requests one at a time
   sdfc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .head              (head),
      .qstat             (qstat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_visible       (rsp_visible),
      .rsp_cull_reason   (rsp_cull_reason),
      .rsp_distance_sq   (rsp_distance_sq),
      .rsp_total_count   (rsp_total_count),
      .rsp_visible_count (rsp_visible_count),
      .rsp_culled_count  (rsp_culled_count),
      .rsp_nearest_sq    (rsp_nearest_sq),
      .rsp_farthest_sq   (rsp_farthest_sq)
   );

endmodule
`default_nettype wire
